// ----- rtl/bounded_ordered_list_engine_unit_defines.svh -----
// Assertion macros used by the list engine datapath.
`ifndef BOUNDED_ORDERED_LIST_ENGINE_UNIT_DEFINES_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define BOLE_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bole: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define BOLE_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bole: next-cycle check failed");

`endif

// ----- rtl/bole_pkg.sv -----
// Shared constants, codes and control structs of the list engine.
package bole_pkg;

	localparam int CAPACITY = 32;
	localparam int IW       = $clog2(CAPACITY);
	localparam int CW       = 7;
	localparam int DATA_W   = 32;
	localparam int POS_W    = 7;
	localparam int CMD_W    = 3;
	localparam int ST_W     = 2;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 48;

	localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INS_AT    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DEL_BACK  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_DEL_AT    = 3'd5;
	localparam logic [CMD_W-1:0] CMD_LIST      = 3'd6;

	localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
	localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
	localparam logic [ST_W-1:0] ST_EMPTY  = 2'd3;

	typedef struct packed {
		logic accept;
		logic setup;
		logic shift_en;
		logic finish;
		logic resp_load;
		logic list_rd;
		logic list_emit;
	} dp_cmd_t;

	typedef struct packed {
		logic is_list;
		logic empty;
		logic proceed;
		logic busy;
		logic slot_free;
		logic more;
	} dp_stat_t;

endpackage

// ----- rtl/bounded_ordered_list_engine_unit.sv -----
// Top level of the bounded ordered list engine: controller plus datapath.
//
// channel  dir  tdata                                      tuser       tlast
// s_*      in   [31:0] item_value, [38:32] position        [2:0] cmd   -
// m_*      out  [31:0] elem_value, [38:32] elem_index,     [1:0] status last
//               [45:39] count
//
// One command at a time. A refused or trivial command goes from decode straight to the
// response; an insert or delete passes through decode, shift, finish and response,
// the shift moving the entries one per cycle through the store's separate read and
// write ports, with one more write to drain the registered read. A list emits its
// elements one per cycle while the output register is free to take them. A new command
// is accepted while a result still waits.
// m_tready low stalls the engine only where it next needs the output register.
// arst_n clears the element count and all control; the store itself is not cleared.
module bounded_ordered_list_engine_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [bole_pkg::S_TDATA_W-1:0] s_tdata,  // item_value, position
	input  logic [bole_pkg::CMD_W-1:0]     s_tuser,  // cmd
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [bole_pkg::M_TDATA_W-1:0] m_tdata,  // elem_value, elem_index, count
	output logic [bole_pkg::ST_W-1:0]      m_tuser,  // status
	output logic                           m_tlast
);
	import bole_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	bole_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	bole_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast),
		.cmd     (cmd),
		.stat    (stat)
	);

endmodule

// ----- rtl/bole_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bole_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/bole_ctrl.sv -----
// Controller state machine of the list engine.
module bole_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  bole_pkg::dp_stat_t stat,
	output bole_pkg::dp_cmd_t  cmd
);
	import bole_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_SHIFT  = 3'd2;
	localparam logic [2:0] S_FINISH = 3'd3;
	localparam logic [2:0] S_RESP   = 3'd4;
	localparam logic [2:0] S_LSTART = 3'd5;
	localparam logic [2:0] S_LEMIT  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.setup = 1'b1;
				priority if (stat.is_list && !stat.empty) begin
					state_d = S_LSTART;
				end else if (stat.proceed) begin
					state_d = S_SHIFT;
				end else begin
					state_d = S_RESP;
				end
			end
			S_SHIFT: begin
				cmd.shift_en = 1'b1;
				if (!stat.busy) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = S_RESP;
			end
			S_RESP: begin
				if (stat.slot_free) begin
					cmd.resp_load = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_LSTART: begin
				cmd.list_rd = 1'b1;
				state_d     = S_LEMIT;
			end
			S_LEMIT: begin
				if (stat.slot_free) begin
					cmd.list_emit = 1'b1;
					if (stat.more) begin
						cmd.list_rd = 1'b1;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/bole_dp.sv -----
// Datapath of the list engine: command decode, element store, shifter, output register.
`include "bounded_ordered_list_engine_unit_defines.svh"

module bole_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [bole_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic [bole_pkg::CMD_W-1:0]       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [bole_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic [bole_pkg::ST_W-1:0]        m_tuser,
	output logic                             m_tlast,
	input  bole_pkg::dp_cmd_t                cmd,
	output bole_pkg::dp_stat_t               stat
);
	import bole_pkg::*;

	// latched command
	logic [CMD_W-1:0]  cmd_q;
	logic [DATA_W-1:0] val_q;
	logic [POS_W-1:0]  pos_q;

	logic [CW-1:0]     cnt_q;
	logic [ST_W-1:0]   st_q;
	logic              ins_q;
	logic              del_q;
	logic [IW-1:0]     tp_q;
	logic [IW-1:0]     ptr_q;
	logic [CW-1:0]     mv_q;
	logic              pend_q;
	logic [IW-1:0]     src_q;

	logic              out_valid_q;
	logic [ST_W-1:0]   out_st_q;
	logic [DATA_W-1:0] out_val_q;
	logic [CW-1:0]     out_idx_q;
	logic [CW-1:0]     out_cnt_q;
	logic              out_last_q;

	// decode
	logic [ST_W-1:0] st_c;
	logic            ins_c;
	logic            del_c;
	logic            list_c;
	logic [CW-1:0]   tp_c;
	logic            full_c;
	logic            empty_c;

	logic              slot_free;
	logic              rd_en;
	logic              we;
	logic [IW-1:0]     waddr;
	logic [DATA_W-1:0] wdata;
	logic [DATA_W-1:0] rdata;

	assign full_c  = (cnt_q >= CW'(CAPACITY));
	assign empty_c = (cnt_q == '0);

	always_comb begin
		st_c   = ST_DONE;
		ins_c  = 1'b0;
		del_c  = 1'b0;
		list_c = 1'b0;
		tp_c   = '0;
		unique case (cmd_q)
			CMD_INS_FRONT: begin
				if (full_c) st_c = ST_FULL;
				else ins_c = 1'b1;
			end
			CMD_INS_BACK: begin
				tp_c = cnt_q;
				if (full_c) st_c = ST_FULL;
				else ins_c = 1'b1;
			end
			CMD_INS_AT: begin
				tp_c = pos_q - 7'd1;
				priority if (pos_q == '0 || pos_q > cnt_q + 7'd1) st_c = ST_BADPOS;
				else if (full_c) st_c = ST_FULL;
				else ins_c = 1'b1;
			end
			CMD_DEL_FRONT: begin
				if (empty_c) st_c = ST_EMPTY;
				else del_c = 1'b1;
			end
			CMD_DEL_BACK: begin
				tp_c = cnt_q - 7'd1;
				if (empty_c) st_c = ST_EMPTY;
				else del_c = 1'b1;
			end
			CMD_DEL_AT: begin
				tp_c = pos_q - 7'd1;
				priority if (empty_c) st_c = ST_EMPTY;
				else if (pos_q == '0 || pos_q > cnt_q) st_c = ST_BADPOS;
				else del_c = 1'b1;
			end
			CMD_LIST: begin
				list_c = 1'b1;
				if (empty_c) st_c = ST_EMPTY;
			end
			default: begin
				st_c = ST_DONE;
			end
		endcase
	end

	assign slot_free = !out_valid_q || m_tready;

	assign stat.is_list   = list_c;
	assign stat.empty     = empty_c;
	assign stat.proceed   = ins_c || del_c;
	assign stat.busy      = (mv_q != '0) || pend_q;
	assign stat.slot_free = slot_free;
	assign stat.more      = (mv_q != '0);

	// one read per cycle while shifting or listing; list reads wait while the output slot is busy
	assign rd_en = (cmd.shift_en && mv_q != '0) || cmd.list_rd;

	always_comb begin
		we    = 1'b0;
		waddr = tp_q;
		wdata = val_q;
		if (cmd.shift_en && pend_q) begin
			we    = 1'b1;
			waddr = ins_q ? src_q + IW'(1) : src_q - IW'(1);
			wdata = rdata;
		end else if (cmd.finish && ins_q) begin
			we = 1'b1;
		end
	end

	bole_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(DATA_W)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (rd_en),
		.raddr(ptr_q),
		.rdata(rdata)
	);

	// payload latches
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q <= s_tuser;
			val_q <= s_tdata[DATA_W-1:0];
			pos_q <= s_tdata[DATA_W+POS_W-1:DATA_W];
		end
		if (cmd.setup) begin
			st_q <= st_c;
			tp_q <= tp_c[IW-1:0];
		end
		if (rd_en) begin
			src_q <= ptr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			ins_q  <= 1'b0;
			del_q  <= 1'b0;
			ptr_q  <= '0;
			mv_q   <= '0;
			pend_q <= 1'b0;
		end else begin
			pend_q <= cmd.shift_en && mv_q != '0;
			if (cmd.setup) begin
				ins_q <= ins_c;
				del_q <= del_c;
				priority if (list_c) begin
					ptr_q <= '0;
					mv_q  <= cnt_q;
				end else if (ins_c) begin
					ptr_q <= IW'(cnt_q - 7'd1);
					mv_q  <= cnt_q - tp_c;
				end else begin
					ptr_q <= IW'(tp_c + 7'd1);
					mv_q  <= cnt_q - 7'd1 - tp_c;
				end
			end else if (rd_en) begin
				ptr_q <= (cmd.shift_en && ins_q) ? ptr_q - IW'(1) : ptr_q + IW'(1);
				mv_q  <= mv_q - 7'd1;
			end
			if (cmd.finish) begin
				priority if (ins_q) cnt_q <= cnt_q + 7'd1;
				else if (del_q) cnt_q <= cnt_q - 7'd1;
				else cnt_q <= cnt_q;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.resp_load || cmd.list_emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.resp_load) begin
			out_st_q   <= st_q;
			out_val_q  <= '0;
			out_idx_q  <= '0;
			out_cnt_q  <= cnt_q;
			out_last_q <= 1'b1;
		end else if (cmd.list_emit) begin
			out_st_q   <= ST_DONE;
			out_val_q  <= rdata;
			out_idx_q  <= cnt_q - mv_q;
			out_cnt_q  <= cnt_q;
			out_last_q <= (mv_q == '0);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_cnt_q, out_idx_q, out_val_q};
	assign m_tuser  = out_st_q;
	assign m_tlast  = out_last_q;

	`BOLE_ASSERT_IMP(a_cnt_max, 1'b1, cnt_q <= CW'(CAPACITY))
	`BOLE_ASSERT_IMP(a_load_slot, cmd.resp_load || cmd.list_emit, slot_free)
	`BOLE_ASSERT_IMP(a_ins_room, cmd.finish && ins_q, cnt_q < CW'(CAPACITY))
	`BOLE_ASSERT_NXT(a_list_last, cmd.list_emit && mv_q == '0, out_last_q && out_idx_q == out_cnt_q)

endmodule
